// File: src/assert_macros.svh
// Assertion macros used by the top level of the input qualifier.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every rising edge outside reset.
`define BJIQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a rising edge outside reset.
`define BJIQ_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define BJIQ_ASSERT(label, clk, rst_n, prop, msg)
`define BJIQ_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// File: src/bjiq_pkg.sv
// Package of the button and joystick input qualifier: widths, codes,
// beat types and register reset values. Depends on nothing.
package bjiq_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int THR_BITS    = 12;
    localparam int CMP_W       = ((SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS) + 2;
    localparam int MAX_RES     = 3;
    localparam int NUM_CAND    = 5;

    localparam logic [5:0] BUTTON_IDLE = 6'h3F;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_UP    = 3'd1,
        EV_DOWN  = 3'd2,
        EV_LEFT  = 3'd3,
        EV_RIGHT = 3'd4,
        EV_BACK  = 3'd5
    } ev_code_t;

    localparam logic [2:0] CFG_LOCKOUT   = 3'd0;
    localparam logic [2:0] CFG_LOW_THR   = 3'd1;
    localparam logic [2:0] CFG_HIGH_THR  = 3'd2;
    localparam logic [2:0] CFG_REL_OFS   = 3'd3;
    localparam logic [2:0] CFG_BEEP      = 3'd4;

    localparam logic [15:0]         LOCKOUT_RST = 16'd200;
    localparam logic [THR_BITS-1:0] LOW_RST     = 12'd1000;
    localparam logic [THR_BITS-1:0] HIGH_RST    = 12'd3000;
    localparam logic [THR_BITS-1:0] REL_RST     = 12'd500;
    localparam logic [15:0]         BEEP_RST    = 16'd100;

    typedef struct packed {
        logic [5:0]             raw_buttons;
        logic [SAMPLE_BITS-1:0] stick_x;
        logic [SAMPLE_BITS-1:0] stick_y;
        logic [31:0]            now_ms;
    } in_item_t;

    typedef struct packed {
        ev_code_t event_res;
        logic     buzzer_on;
        logic     last;
    } out_item_t;

    typedef struct packed {
        logic [15:0]         lockout_ms;
        logic [THR_BITS-1:0] low_threshold;
        logic [THR_BITS-1:0] high_threshold;
        logic [THR_BITS-1:0] release_offset;
        logic [15:0]         beep_ms;
    } cfg_t;

    // Outcome of one tick handed from the evaluation stage to the result buffer.
    typedef struct packed {
        ev_code_t [MAX_RES-1:0] events;
        logic [1:0]             count;
        logic                   buzzer_on;
    } tick_res_t;

endpackage

// File: src/bjiq_cfg.sv
// Configuration register file of the input qualifier.
// Depends on bjiq_pkg for the register indexes and reset values.
module bjiq_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    output bjiq_pkg::cfg_t cfg
);
    import bjiq_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LOCKOUT:  cfg_next.lockout_ms     = cfg_data[15:0];
                CFG_LOW_THR:  cfg_next.low_threshold  = cfg_data[THR_BITS-1:0];
                CFG_HIGH_THR: cfg_next.high_threshold = cfg_data[THR_BITS-1:0];
                CFG_REL_OFS:  cfg_next.release_offset = cfg_data[THR_BITS-1:0];
                CFG_BEEP:     cfg_next.beep_ms        = cfg_data[15:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lockout_ms     <= LOCKOUT_RST;
            cfg_reg.low_threshold  <= LOW_RST;
            cfg_reg.high_threshold <= HIGH_RST;
            cfg_reg.release_offset <= REL_RST;
            cfg_reg.beep_ms        <= BEEP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: src/bjiq_eval.sv
// Tick evaluation of the input qualifier: edge detection, joystick latches,
// lockout and beep timing, with the state they keep. Depends on bjiq_pkg.
module bjiq_eval (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  bjiq_pkg::in_item_t  item,
    input  bjiq_pkg::cfg_t      cfg,
    output bjiq_pkg::tick_res_t res
);
    import bjiq_pkg::*;

    logic [5:0]  prev_buttons_reg, prev_buttons_next;
    logic [31:0] last_event_reg, last_event_next;
    logic        latch_up_reg, latch_up_next;
    logic        latch_down_reg, latch_down_next;
    logic        latch_left_reg, latch_left_next;
    logic        latch_right_reg, latch_right_next;
    logic        beep_active_reg, beep_active_next;
    logic [31:0] beep_start_reg, beep_start_next;

    logic [5:0]       fall, rise;
    logic             lock_ok, joy_ok;
    logic             btn_fire;
    ev_code_t         btn_code;
    logic [CMP_W-1:0] sx, sy, low_w, high_w, ofs_w, up_rel_lvl, dn_rel_lvl;
    logic             up_rel_ok;
    logic             up_fire, down_fire, left_fire, right_fire;
    logic             up_rel, down_rel, left_rel, right_rel;
    logic [NUM_CAND-1:0] cand_fire;
    ev_code_t [NUM_CAND-1:0] cand_code;
    ev_code_t [MAX_RES-1:0]  ev_list;
    logic [2:0]       n_ev;
    logic             any_event;
    logic [31:0]      beep_start_mid;
    logic             beep_mid;

    assign fall    = prev_buttons_reg & ~item.raw_buttons;
    assign rise    = item.raw_buttons & ~prev_buttons_reg;
    assign lock_ok = (item.now_ms - last_event_reg) >= {16'd0, cfg.lockout_ms};

    always_comb
    begin
        btn_fire = lock_ok;
        btn_code = EV_NONE;
        priority if (fall[0]) btn_code = EV_UP;
        else if (fall[1])     btn_code = EV_DOWN;
        else if (fall[2])     btn_code = EV_LEFT;
        else if (fall[3])     btn_code = EV_RIGHT;
        else if (fall[4] || rise[5]) btn_code = EV_BACK;
        else                  btn_fire = 1'b0;
    end

    // A button event moves the last event time to now, so the joystick then
    // sees a zero distance and passes only with a zero lockout.
    assign joy_ok = btn_fire ? (cfg.lockout_ms == 16'd0) : lock_ok;

    assign sx        = CMP_W'(item.stick_x);
    assign sy        = CMP_W'(item.stick_y);
    assign low_w     = CMP_W'(cfg.low_threshold);
    assign high_w    = CMP_W'(cfg.high_threshold);
    assign ofs_w     = CMP_W'(cfg.release_offset);
    assign up_rel_ok = cfg.high_threshold >= cfg.release_offset;
    assign up_rel_lvl = high_w - ofs_w;
    assign dn_rel_lvl = low_w + ofs_w;

    assign up_fire    = joy_ok && !latch_up_reg    && (sy > high_w);
    assign down_fire  = joy_ok && !latch_down_reg  && (sy < low_w);
    assign left_fire  = joy_ok && !latch_left_reg  && (sx > high_w);
    assign right_fire = joy_ok && !latch_right_reg && (sx < low_w);
    assign up_rel     = joy_ok && latch_up_reg    && up_rel_ok && (sy < up_rel_lvl);
    assign down_rel   = joy_ok && latch_down_reg  && (sy > dn_rel_lvl);
    assign left_rel   = joy_ok && latch_left_reg  && up_rel_ok && (sx < up_rel_lvl);
    assign right_rel  = joy_ok && latch_right_reg && (sx > dn_rel_lvl);

    assign cand_fire = {right_fire, left_fire, down_fire, up_fire, btn_fire};
    assign cand_code = {EV_RIGHT, EV_LEFT, EV_DOWN, EV_UP, btn_code};

    // Pack the events of this tick in order, keeping the first three.
    always_comb
    begin
        ev_list = {MAX_RES{EV_NONE}};
        n_ev    = 3'd0;
        for (int k = 0; k < NUM_CAND; k++)
        begin
            if (cand_fire[k] && (n_ev < 3'(MAX_RES)))
            begin
                ev_list[n_ev[1:0]] = cand_code[k];
                n_ev = n_ev + 3'd1;
            end
        end
    end

    assign any_event      = |cand_fire;
    assign beep_start_mid = any_event ? item.now_ms : beep_start_reg;
    assign beep_mid       = (any_event || beep_active_reg)
                            && !((item.now_ms - beep_start_mid) >= {16'd0, cfg.beep_ms});

    assign res.events    = ev_list;
    assign res.count     = (n_ev == 3'd0) ? 2'd1 : n_ev[1:0];
    assign res.buzzer_on = beep_mid;

    always_comb
    begin
        prev_buttons_next = prev_buttons_reg;
        last_event_next   = last_event_reg;
        latch_up_next     = latch_up_reg;
        latch_down_next   = latch_down_reg;
        latch_left_next   = latch_left_reg;
        latch_right_next  = latch_right_reg;
        beep_active_next  = beep_active_reg;
        beep_start_next   = beep_start_reg;
        if (step)
        begin
            prev_buttons_next = item.raw_buttons;
            last_event_next   = any_event ? item.now_ms : last_event_reg;
            latch_up_next     = (latch_up_reg    || up_fire)    && !up_rel;
            latch_down_next   = (latch_down_reg  || down_fire)  && !down_rel;
            latch_left_next   = (latch_left_reg  || left_fire)  && !left_rel;
            latch_right_next  = (latch_right_reg || right_fire) && !right_rel;
            beep_active_next  = beep_mid;
            beep_start_next   = beep_start_mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_buttons_reg <= BUTTON_IDLE;
            last_event_reg   <= 32'd0;
            latch_up_reg     <= 1'b0;
            latch_down_reg   <= 1'b0;
            latch_left_reg   <= 1'b0;
            latch_right_reg  <= 1'b0;
            beep_active_reg  <= 1'b0;
            beep_start_reg   <= 32'd0;
        end
        else
        begin
            prev_buttons_reg <= prev_buttons_next;
            last_event_reg   <= last_event_next;
            latch_up_reg     <= latch_up_next;
            latch_down_reg   <= latch_down_next;
            latch_left_reg   <= latch_left_next;
            latch_right_reg  <= latch_right_next;
            beep_active_reg  <= beep_active_next;
            beep_start_reg   <= beep_start_next;
        end
    end

endmodule

// File: src/bjiq_res_buf.sv
// Result buffer of the input qualifier: holds the events of one tick and
// sends them as beats, one per cycle while out_stall is low. Depends on bjiq_pkg.
module bjiq_res_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  bjiq_pkg::tick_res_t  res,
    output logic                 load_ok,
    output logic                 out_valid,
    input  logic                 out_stall,
    output bjiq_pkg::out_item_t  out_data
);
    import bjiq_pkg::*;

    logic                   vld_reg, vld_next;
    ev_code_t [MAX_RES-1:0] ev_reg, ev_next;
    logic [1:0]             cnt_reg, cnt_next;
    logic [1:0]             idx_reg, idx_next;
    logic                   buz_reg, buz_next;
    logic                   take, last_beat;

    assign last_beat = (idx_reg + 2'd1) == cnt_reg;
    assign take      = vld_reg && !out_stall;
    assign load_ok   = !vld_reg || (take && last_beat);

    assign out_valid          = vld_reg;
    assign out_data.event_res = ev_reg[idx_reg];
    assign out_data.buzzer_on = buz_reg;
    assign out_data.last      = last_beat;

    always_comb
    begin
        vld_next = vld_reg;
        ev_next  = ev_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        buz_next = buz_reg;
        if (load)
        begin
            vld_next = 1'b1;
            ev_next  = res.events;
            cnt_next = res.count;
            idx_next = 2'd0;
            buz_next = res.buzzer_on;
        end
        else if (take)
        begin
            vld_next = !last_beat;
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            cnt_reg <= 2'd1;
            idx_reg <= 2'd0;
        end
        else
        begin
            vld_reg <= vld_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg  <= ev_next;
        buz_reg <= buz_next;
    end

endmodule

// File: src/button_joystick_input_qualifier.sv
// Top level of the button and joystick input qualifier.
// Depends on bjiq_pkg, bjiq_cfg, bjiq_eval, bjiq_res_buf and assert_macros.svh.
//
// Usage. Each input beat on in_data is one tick: six raw button levels, the X
// and Y joystick samples and a millisecond timestamp. A beat is taken at a
// rising edge with in_valid high and in_stall low. For every tick the block
// returns one to three output beats on out_data, each with an event code, the
// buzzer level after the tick and a last flag on the final beat of the tick.
// A quiet tick gives a single beat with event code none.
// A taken tick waits in the input register, is evaluated combinationally and
// goes into the result register, which sends its beats. Throughput: one tick
// per cycle while every tick yields a single beat and the receiver does not
// stall; a tick with two or three events holds the result register until its
// final beat is taken, as it sends its beats one at a time. On a receiver
// stall the result register holds its beat; an empty input register takes
// one more tick, and in_stall is high while it holds one. The configuration
// channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready; the
// user is to write it only while the block is idle, which the block does not
// enforce. Indexes beyond the register list are ignored. Reset clears the
// handshake state and restores the register defaults, latches and timers.
`include "assert_macros.svh"

module button_joystick_input_qualifier (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  bjiq_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output bjiq_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import bjiq_pkg::*;

    logic      in_vld_reg, in_vld_next;
    in_item_t  in_data_reg, in_data_next;
    logic      advance;
    logic      load_ok;
    cfg_t      cfg;
    tick_res_t tick_res;

    // The held tick moves on into the result register whenever that register
    // is empty or is sending its final beat in this cycle.
    assign advance  = in_vld_reg && load_ok;
    assign in_stall = in_vld_reg && !load_ok;

    always_comb
    begin
        in_vld_next  = in_vld_reg;
        in_data_next = in_data_reg;
        if (!in_stall)
        begin
            in_vld_next  = in_valid;
            in_data_next = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_data_reg <= in_data_next;
    end

    bjiq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bjiq_eval u_eval (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_data_reg),
        .cfg   (cfg),
        .res   (tick_res)
    );

    bjiq_res_buf u_res_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res       (tick_res),
        .load_ok   (load_ok),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // An evaluated tick always shows up as a result beat in the next cycle.
    `BJIQ_ASSERT(a_advance_gives_beat, clk, rst_n, advance |=> out_valid, "tick lost after evaluation")
    // A final beat taken with nothing behind it leaves the output empty.
    `BJIQ_ASSERT(a_last_empties, clk, rst_n, (out_valid && !out_stall && out_data.last && !advance) |=> !out_valid, "beat repeated after last")
    // A beat with no event can only be the single beat of a quiet tick.
    `BJIQ_ASSERT(a_quiet_is_last, clk, rst_n, (out_valid && (out_data.event_res == EV_NONE)) |-> out_data.last, "quiet beat not last")
    // The input side only stalls while a tick is held.
    `BJIQ_NEVER(a_stall_needs_item, clk, rst_n, in_stall && !in_vld_reg, "stall with empty input register")

endmodule
